// ===== hdl/bcc_pkg.sv =====
// Shared types and constants for the button click classifier.
package bcc_pkg;

    // Default counter width for elapsed and debounce counters
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Configuration register width and address width
    localparam int CFG_WIDTH   = 16;
    localparam int PADDR_WIDTH = 5;
    localparam int PDATA_WIDTH = 32;

    // Configuration register indexes (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_DEBOUNCE_TICKS     = 3'd0,
        REG_SHORT_TICKS        = 3'd1,
        REG_DOUBLE_TICKS       = 3'd2,
        REG_DEFAULT_LONG_TICKS = 3'd3,
        REG_CUSTOM_LONG_TICKS  = 3'd4,
        REG_CUSTOM_LONG_ENABLE = 3'd5
    } reg_index_t;

    // Configuration reset values
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RST     = 16'd2;
    localparam logic [CFG_WIDTH-1:0] SHORT_TICKS_RST        = 16'd10;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_TICKS_RST       = 16'd30;
    localparam logic [CFG_WIDTH-1:0] DEFAULT_LONG_TICKS_RST = 16'd100;
    localparam logic [CFG_WIDTH-1:0] CUSTOM_LONG_TICKS_RST  = 16'd0;
    localparam logic                 CUSTOM_LONG_ENABLE_RST = 1'b0;

    // Click phase machine, one-hot
    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_PRESSED  = 4'b0010,
        PH_RELEASED = 4'b0100,
        PH_HOLD     = 4'b1000
    } phase_t;

    // Reported event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    // Press count values
    localparam logic [1:0] PRESS_NONE   = 2'd0;
    localparam logic [1:0] PRESS_FIRST  = 2'd1;
    localparam logic [1:0] PRESS_SECOND = 2'd2;

endpackage

// ===== hdl/button_click_classifier.sv =====
// Button click classifier: debounce, click phase machine, result register, APB registers.
//
// Usage:
//   s_valid/s_ready/s_pin_level carry one tick transaction each: the sampled
//   button pin. Every accepted tick yields exactly one result transaction on
//   m_valid/m_ready with m_event_code (0 none, 1 single click, 2 double click,
//   3 long hold) and m_pressed_now (debounced level after that tick).
//   The result is in the output register on the cycle after acceptance.
//   Throughput is one tick per cycle, set by the single
//   output register; s_ready stays high while that register is empty or is
//   being drained in the same cycle.
//   When the receiver stalls, the pending result holds in the output register
//   and s_ready drops until it is taken; no tick is lost.
//   The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
//   six registers at byte addresses 0..20; pready is always high and writes
//   are meant to happen while no tick is in flight.
//   Reset (aresetn low, synchronous) restores the register defaults, clears
//   the debounced level, counters and phase to idle, and empties the output.
module button_click_classifier #(
    parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tick input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_pin_level,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_event_code,
    output logic                             m_pressed_now,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bcc_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [bcc_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [bcc_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                             pready
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > bcc_pkg::CFG_WIDTH) ?
                               COUNT_WIDTH : bcc_pkg::CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration registers
    logic [bcc_pkg::CFG_WIDTH-1:0] debounce_ticks_reg;
    logic [bcc_pkg::CFG_WIDTH-1:0] short_ticks_reg;
    logic [bcc_pkg::CFG_WIDTH-1:0] double_ticks_reg;
    logic [bcc_pkg::CFG_WIDTH-1:0] default_long_ticks_reg;
    logic [bcc_pkg::CFG_WIDTH-1:0] custom_long_ticks_reg;
    logic                          custom_long_enable_reg;

    // Tick state
    logic                   level_reg, level_next;
    bcc_pkg::phase_t        phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0] debounce_reg, debounce_next;
    logic [1:0]             press_reg, press_next;

    // Result register
    logic                   m_valid_reg;
    bcc_pkg::event_t        event_reg, event_next;
    logic                   pressed_reg;

    // Combinational helpers
    logic [COUNT_WIDTH-1:0]        elapsed_inc;
    logic [COUNT_WIDTH-1:0]        debounce_inc;
    logic [bcc_pkg::CFG_WIDTH-1:0] long_thr;
    logic [CMP_WIDTH-1:0]          elapsed_cmp;
    logic                          s_accept;
    logic                          cfg_write;
    bcc_pkg::reg_index_t           cfg_index;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = bcc_pkg::reg_index_t'(paddr[bcc_pkg::PADDR_WIDTH-1:2]);

    assign m_valid       = m_valid_reg;
    assign m_event_code  = event_reg;
    assign m_pressed_now = pressed_reg;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg     <= bcc_pkg::DEBOUNCE_TICKS_RST;
            short_ticks_reg        <= bcc_pkg::SHORT_TICKS_RST;
            double_ticks_reg       <= bcc_pkg::DOUBLE_TICKS_RST;
            default_long_ticks_reg <= bcc_pkg::DEFAULT_LONG_TICKS_RST;
            custom_long_ticks_reg  <= bcc_pkg::CUSTOM_LONG_TICKS_RST;
            custom_long_enable_reg <= bcc_pkg::CUSTOM_LONG_ENABLE_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                bcc_pkg::REG_DEBOUNCE_TICKS:
                    debounce_ticks_reg <= pwdata[bcc_pkg::CFG_WIDTH-1:0];
                bcc_pkg::REG_SHORT_TICKS:
                    short_ticks_reg <= pwdata[bcc_pkg::CFG_WIDTH-1:0];
                bcc_pkg::REG_DOUBLE_TICKS:
                    double_ticks_reg <= pwdata[bcc_pkg::CFG_WIDTH-1:0];
                bcc_pkg::REG_DEFAULT_LONG_TICKS:
                    default_long_ticks_reg <= pwdata[bcc_pkg::CFG_WIDTH-1:0];
                bcc_pkg::REG_CUSTOM_LONG_TICKS:
                    custom_long_ticks_reg <= pwdata[bcc_pkg::CFG_WIDTH-1:0];
                bcc_pkg::REG_CUSTOM_LONG_ENABLE:
                    custom_long_enable_reg <= pwdata[0];
                default: ; // unmapped addresses ignored
            endcase
        end
    end

    // Register read
    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            bcc_pkg::REG_DEBOUNCE_TICKS:
                prdata = bcc_pkg::PDATA_WIDTH'(debounce_ticks_reg);
            bcc_pkg::REG_SHORT_TICKS:
                prdata = bcc_pkg::PDATA_WIDTH'(short_ticks_reg);
            bcc_pkg::REG_DOUBLE_TICKS:
                prdata = bcc_pkg::PDATA_WIDTH'(double_ticks_reg);
            bcc_pkg::REG_DEFAULT_LONG_TICKS:
                prdata = bcc_pkg::PDATA_WIDTH'(default_long_ticks_reg);
            bcc_pkg::REG_CUSTOM_LONG_TICKS:
                prdata = bcc_pkg::PDATA_WIDTH'(custom_long_ticks_reg);
            bcc_pkg::REG_CUSTOM_LONG_ENABLE:
                prdata = bcc_pkg::PDATA_WIDTH'(custom_long_enable_reg);
            default: prdata = '0;
        endcase
    end

    // Elapsed counter advances first, saturating, outside idle
    always_comb begin
        elapsed_inc = elapsed_reg;
        if (phase_reg != bcc_pkg::PH_IDLE && elapsed_reg != COUNT_MAX) begin
            elapsed_inc = elapsed_reg + 1'b1;
        end
    end

    // Debounce: a changed level must persist debounce_ticks ticks
    always_comb begin
        debounce_inc  = (debounce_reg == COUNT_MAX) ? debounce_reg : debounce_reg + 1'b1;
        level_next    = level_reg;
        debounce_next = '0;
        if (level_reg != s_pin_level) begin
            if (CMP_WIDTH'(debounce_inc) >= CMP_WIDTH'(debounce_ticks_reg)) begin
                level_next = s_pin_level;
            end else begin
                debounce_next = debounce_inc;
            end
        end
    end

    // Click phase machine on the new debounced level
    always_comb begin
        long_thr     = custom_long_enable_reg ? custom_long_ticks_reg
                                              : default_long_ticks_reg;
        elapsed_cmp  = CMP_WIDTH'(elapsed_inc);
        phase_next   = phase_reg;
        elapsed_next = elapsed_inc;
        press_next   = press_reg;
        event_next   = bcc_pkg::EV_NONE;
        unique case (phase_reg)
            bcc_pkg::PH_IDLE: begin
                if (level_next) begin
                    phase_next   = bcc_pkg::PH_PRESSED;
                    elapsed_next = '0;
                    press_next   = bcc_pkg::PRESS_FIRST;
                end
            end
            bcc_pkg::PH_PRESSED: begin
                if (!level_next) begin
                    // short releases are ignored
                    if (elapsed_cmp > CMP_WIDTH'(short_ticks_reg)) begin
                        if (press_reg == bcc_pkg::PRESS_FIRST) begin
                            phase_next = bcc_pkg::PH_RELEASED;
                        end else if (press_reg == bcc_pkg::PRESS_SECOND) begin
                            event_next = bcc_pkg::EV_DOUBLE;
                            phase_next = bcc_pkg::PH_IDLE;
                        end
                        elapsed_next = '0;
                    end
                end else if (elapsed_cmp > CMP_WIDTH'(long_thr)) begin
                    phase_next   = bcc_pkg::PH_HOLD;
                    elapsed_next = '0;
                end
            end
            bcc_pkg::PH_RELEASED: begin
                if (level_next) begin
                    press_next   = bcc_pkg::PRESS_SECOND;
                    phase_next   = bcc_pkg::PH_PRESSED;
                    elapsed_next = '0;
                end else if (elapsed_cmp > CMP_WIDTH'(double_ticks_reg)) begin
                    elapsed_next = '0;
                    event_next   = bcc_pkg::EV_SINGLE;
                    phase_next   = bcc_pkg::PH_IDLE;
                end
            end
            bcc_pkg::PH_HOLD: begin
                // long hold reported every tick while held
                if (level_next) begin
                    elapsed_next = '0;
                    event_next   = bcc_pkg::EV_LONG;
                end else begin
                    phase_next = bcc_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = bcc_pkg::PH_IDLE;
            end
        endcase
    end

    // State update on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= 1'b0;
            phase_reg    <= bcc_pkg::PH_IDLE;
            elapsed_reg  <= '0;
            debounce_reg <= '0;
            press_reg    <= bcc_pkg::PRESS_NONE;
        end else if (s_accept) begin
            level_reg    <= level_next;
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            debounce_reg <= debounce_next;
            press_reg    <= press_next;
        end
    end

    // Result register: loads on accept, empties when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            event_reg   <= event_next;
            pressed_reg <= level_next;
        end
    end

endmodule
